/* src/rvs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types and codes of the RV32E step engine: opcodes, function codes,
// trap codes, serial ALU operations and the ALU control and status bundles.
// ----------------------------------------------------------------------------
package rvs_pkg;

   localparam int unsigned MEM_BYTES_DEFAULT = 65536;

   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_OPIMM  = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_JAL    = 7'h6f;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;

   localparam logic [6:0] F7_ZERO = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_SLTU = 3'd3;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;

   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_BLTU = 3'd6;

   localparam logic [2:0] F3_MB  = 3'd0;
   localparam logic [2:0] F3_MH  = 3'd1;
   localparam logic [2:0] F3_MW  = 3'd2;
   localparam logic [2:0] F3_MBU = 3'd4;
   localparam logic [2:0] F3_MHU = 3'd5;

   localparam logic [1:0] TRAP_NONE = 2'd0;
   localparam logic [1:0] TRAP_MEM  = 2'd1;
   localparam logic [1:0] TRAP_ILL  = 2'd2;

   localparam logic REQ_OP_LOAD = 1'b0;

   localparam logic CSR_IDX_CYCLE_LIMIT = 1'b0;

   typedef logic [2:0] alu_op_type;
   localparam alu_op_type ALU_ADD = 3'd0;
   localparam alu_op_type ALU_SUB = 3'd1;
   localparam alu_op_type ALU_XOR = 3'd2;
   localparam alu_op_type ALU_OR  = 3'd3;
   localparam alu_op_type ALU_AND = 3'd4;
   localparam alu_op_type ALU_SLL = 3'd5;
   localparam alu_op_type ALU_SRL = 3'd6;
   localparam alu_op_type ALU_SRA = 3'd7;

   typedef struct packed {
      logic        start;
      alu_op_type  op;
      logic [31:0] x;
      logic [31:0] y;
   } alu_ctrl_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
      logic        eq;
      logic        lt;
      logic        ltu;
   } alu_status_type;

endpackage

/* src/rvs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rvs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/rvs_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_alu
// Serial ALU: add, subtract and logic ops one byte per cycle, shifts one bit
// per cycle. Leaves equal, signed-less and unsigned-less flags after a subtract.
// ----------------------------------------------------------------------------
module rvs_alu (
   input  logic                   clock,
   input  logic                   reset,
   input  rvs_pkg::alu_ctrl_type  ctrl,
   output rvs_pkg::alu_status_type status
);

   logic [31:0]         x_ff, x_in;
   logic [31:0]         y_ff, y_in;
   logic [31:0]         r_ff, r_in;
   logic                carry_ff, carry_in;
   logic                zero_ff, zero_in;
   logic                xs_ff, xs_in;
   logic                ys_ff, ys_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   rvs_pkg::alu_op_type op_ff, op_in;
   logic [4:0]          cnt_ff, cnt_in;

   logic                is_shift;
   logic                start_shift;
   logic [7:0]          yd;
   logic [8:0]          sum;
   logic [7:0]          digit;

   assign is_shift = (op_ff == rvs_pkg::ALU_SLL) || (op_ff == rvs_pkg::ALU_SRL) ||
                     (op_ff == rvs_pkg::ALU_SRA);
   assign start_shift = (ctrl.op == rvs_pkg::ALU_SLL) || (ctrl.op == rvs_pkg::ALU_SRL) ||
                        (ctrl.op == rvs_pkg::ALU_SRA);
   assign yd  = (op_ff == rvs_pkg::ALU_SUB) ? ~y_ff[7:0] : y_ff[7:0];
   assign sum = {1'b0, x_ff[7:0]} + {1'b0, yd} + {8'b0, carry_ff};

   always_comb begin
      case (op_ff)
         rvs_pkg::ALU_XOR: digit = x_ff[7:0] ^ y_ff[7:0];
         rvs_pkg::ALU_OR:  digit = x_ff[7:0] | y_ff[7:0];
         rvs_pkg::ALU_AND: digit = x_ff[7:0] & y_ff[7:0];
         default:          digit = sum[7:0];
      endcase
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      r_in     = r_ff;
      carry_in = carry_ff;
      zero_in  = zero_ff;
      xs_in    = xs_ff;
      ys_in    = ys_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      if (ctrl.start) begin
         x_in     = ctrl.x;
         y_in     = ctrl.y;
         r_in     = ctrl.x;
         op_in    = ctrl.op;
         carry_in = (ctrl.op == rvs_pkg::ALU_SUB);
         zero_in  = 1'b1;
         xs_in    = ctrl.x[31];
         ys_in    = ctrl.y[31];
         busy_in  = 1'b1;
         cnt_in   = start_shift ? ctrl.y[4:0] : 5'd3;
      end else if (busy_ff) begin
         if (is_shift) begin
            if (cnt_ff == 5'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 5'd1;
               case (op_ff)
                  rvs_pkg::ALU_SLL: r_in = {r_ff[30:0], 1'b0};
                  rvs_pkg::ALU_SRA: r_in = {r_ff[31], r_ff[31:1]};
                  default:          r_in = {1'b0, r_ff[31:1]};
               endcase
            end
         end else begin
            r_in     = {digit, r_ff[31:8]};
            x_in     = {8'b0, x_ff[31:8]};
            y_in     = {8'b0, y_ff[31:8]};
            carry_in = sum[8];
            zero_in  = zero_ff & (x_ff[7:0] == y_ff[7:0]);
            cnt_in   = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      r_ff     <= r_in;
      carry_ff <= carry_in;
      zero_ff  <= zero_in;
      xs_ff    <= xs_in;
      ys_ff    <= ys_in;
      op_ff    <= op_in;
      cnt_ff   <= cnt_in;
   end

   assign status.done   = done_ff;
   assign status.result = r_ff;
   assign status.eq     = zero_ff;
   assign status.ltu    = ~carry_ff;
   assign status.lt     = (xs_ff ^ ys_ff) ? xs_ff : ~carry_ff;

endmodule

/* src/rv32e_instruction_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32e_instruction_step
// Multicycle RV32E core with byte memory, sixteen registers, a sticky trap
// code and a retired-instruction count, driven one request beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req_* beat: op 0 stores word_data at byte word_index*4 and clears pc;
//   op 1 executes one instruction. Every request beat gives one rsp_* beat.
//   csr_* port: cycle_limit at address 0; steps are refused once the retired
//   count reaches it.
//   A program word is written byte by byte into the byte memory. A step
//   fetches four bytes from the byte RAM, decodes and reads the register RAM,
//   runs two byte-serial ALU passes (operation, then pc) and retires. Loads
//   and stores add a memory phase between the passes (one memory byte per
//   cycle). A refused step or an out-of-range fetch goes straight to retire,
//   an illegal instruction retires from decode and an out-of-range data
//   access after the address pass. One request is in flight at a time;
//   req_stall is low only while idle, and the core returns to idle as the
//   result beat is set. The result sits in an output register, so the next
//   request is taken while rsp_stall holds the previous beat.
//   Reset: the byte memory is swept to zero, one byte per cycle, while
//   req_stall stays high; registers read as zero.
// ----------------------------------------------------------------------------
module rv32e_instruction_step #(
   parameter int unsigned MEM_BYTES = rvs_pkg::MEM_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [13:0] req_word_index,
   input  logic [31:0] req_word_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_executed,
   output logic [1:0]  rsp_trap_code,
   output logic [31:0] rsp_pc_now,
   output logic        rsp_reg_written,
   output logic [3:0]  rsp_dest_reg,
   output logic [31:0] rsp_dest_value,
   output logic [63:0] rsp_retired_count,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   localparam int unsigned AW        = $clog2(MEM_BYTES);
   localparam logic [32:0] MEM_LIMIT = 33'(MEM_BYTES);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LOAD   = 4'd2;
   localparam logic [3:0] S_FETCH  = 4'd3;
   localparam logic [3:0] S_DECODE = 4'd4;
   localparam logic [3:0] S_RS1    = 4'd5;
   localparam logic [3:0] S_RS2    = 4'd6;
   localparam logic [3:0] S_START1 = 4'd7;
   localparam logic [3:0] S_WAIT1  = 4'd8;
   localparam logic [3:0] S_MEM    = 4'd9;
   localparam logic [3:0] S_START2 = 4'd10;
   localparam logic [3:0] S_WAIT2  = 4'd11;
   localparam logic [3:0] S_FINISH = 4'd12;

   logic [3:0]    state_ff, state_in;
   logic [31:0]   pc_ff, pc_in;
   logic [63:0]   count_ff, count_in;
   logic [1:0]    trap_ff, trap_in;
   logic [63:0]   limit_ff, limit_in;
   logic [31:0]   ins_ff, ins_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   b_ff, b_in;
   logic [31:0]   res_ff, res_in;
   logic [31:0]   val_ff, val_in;
   logic [31:0]   next_pc_ff, next_pc_in;
   logic          exec_ff, exec_in;
   logic          wres_ff, wres_in;
   logic          inrange_ff, inrange_in;
   logic          eq_ff, eq_in;
   logic          lt_ff, lt_in;
   logic          ltu_ff, ltu_in;
   logic [2:0]    k_ff, k_in;
   logic [AW-1:0] maddr_ff, maddr_in;
   logic [15:0]   valid_ff, valid_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_executed_ff, rsp_executed_in;
   logic [1:0]    rsp_trap_code_ff, rsp_trap_code_in;
   logic [31:0]   rsp_pc_now_ff, rsp_pc_now_in;
   logic          rsp_reg_written_ff, rsp_reg_written_in;
   logic [3:0]    rsp_dest_reg_ff, rsp_dest_reg_in;
   logic [31:0]   rsp_dest_value_ff, rsp_dest_value_in;
   logic [63:0]   rsp_retired_count_ff, rsp_retired_count_in;

   logic          mem_we;
   logic [7:0]    mem_wdata;
   logic [7:0]    mem_rdata;
   logic          rf_we;
   logic [3:0]    rf_raddr;
   logic [3:0]    rf_vaddr;
   logic [31:0]   rf_rdata;
   logic [31:0]   rf_value;

   rvs_pkg::alu_ctrl_type   alu_ctrl;
   rvs_pkg::alu_status_type alu_st;

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
   logic        legal;
   logic        rd_ok, rs1_ok, rs2_ok;
   logic        is_load, is_store, is_branch, is_jump;
   logic [2:0]  acc_size;
   logic [1:0]  lane;
   logic        taken;
   logic [31:0] load_ext;
   logic        slot_free;
   logic        commit_wr;
   logic        csr_write;

   rvs_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (alu_ctrl),
      .status (alu_st)
   );

   rvs_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_byte_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (maddr_ff),
      .wr_data (mem_wdata),
      .rd_addr (maddr_ff),
      .rd_data (mem_rdata)
   );

   rvs_ram #(.WIDTH(32), .DEPTH(16)) u_reg_ram (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rd[3:0]),
      .wr_data (val_ff),
      .rd_addr (rf_raddr),
      .rd_data (rf_rdata)
   );

   // Decode fields
   assign opc    = ins_ff[6:0];
   assign rd     = ins_ff[11:7];
   assign f3     = ins_ff[14:12];
   assign rs1    = ins_ff[19:15];
   assign rs2    = ins_ff[24:20];
   assign f7     = ins_ff[31:25];
   assign imm_i  = {{20{ins_ff[31]}}, ins_ff[31:20]};
   assign imm_s  = {{20{ins_ff[31]}}, ins_ff[31:25], ins_ff[11:7]};
   assign imm_b  = {{19{ins_ff[31]}}, ins_ff[31], ins_ff[7], ins_ff[30:25],
                    ins_ff[11:8], 1'b0};
   assign imm_j  = {{11{ins_ff[31]}}, ins_ff[31], ins_ff[19:12], ins_ff[20],
                    ins_ff[30:21], 1'b0};
   assign imm_u  = {ins_ff[31:12], 12'b0};
   assign rd_ok  = ~rd[4];
   assign rs1_ok = ~rs1[4];
   assign rs2_ok = ~rs2[4];

   assign is_load   = (opc == rvs_pkg::OPC_LOAD);
   assign is_store  = (opc == rvs_pkg::OPC_STORE);
   assign is_branch = (opc == rvs_pkg::OPC_BRANCH);
   assign is_jump   = (opc == rvs_pkg::OPC_JAL) || (opc == rvs_pkg::OPC_JALR);

   always_comb begin
      unique case (opc) inside
         rvs_pkg::OPC_OP:
            legal = rd_ok & rs1_ok & rs2_ok &
                    ((f7 == rvs_pkg::F7_ZERO) ||
                     ((f7 == rvs_pkg::F7_ALT) &&
                      ((f3 == rvs_pkg::F3_ADD) || (f3 == rvs_pkg::F3_SR))));
         rvs_pkg::OPC_OPIMM:
            legal = rd_ok & rs1_ok &
                    ((f3 == rvs_pkg::F3_SLL) ? (f7 == rvs_pkg::F7_ZERO) :
                     (f3 == rvs_pkg::F3_SR)  ? ((f7 == rvs_pkg::F7_ZERO) ||
                                                (f7 == rvs_pkg::F7_ALT)) : 1'b1);
         rvs_pkg::OPC_LOAD:
            legal = rd_ok & rs1_ok &
                    ((f3 == rvs_pkg::F3_MB) || (f3 == rvs_pkg::F3_MH) ||
                     (f3 == rvs_pkg::F3_MW) || (f3 == rvs_pkg::F3_MBU) ||
                     (f3 == rvs_pkg::F3_MHU));
         rvs_pkg::OPC_STORE:
            legal = rs1_ok & rs2_ok &
                    ((f3 == rvs_pkg::F3_MB) || (f3 == rvs_pkg::F3_MH) ||
                     (f3 == rvs_pkg::F3_MW));
         rvs_pkg::OPC_JALR:
            legal = rd_ok & rs1_ok & (f3 == rvs_pkg::F3_ADD);
         rvs_pkg::OPC_BRANCH:
            legal = rs1_ok & rs2_ok & (f3 != rvs_pkg::F3_SLT) & (f3 != rvs_pkg::F3_SLTU);
         rvs_pkg::OPC_JAL, rvs_pkg::OPC_LUI, rvs_pkg::OPC_AUIPC:
            legal = rd_ok;
         default:
            legal = 1'b0;
      endcase
   end

   always_comb begin
      case (f3[1:0])
         2'd0:    acc_size = 3'd1;
         2'd1:    acc_size = 3'd2;
         default: acc_size = 3'd4;
      endcase
   end

   assign lane = 2'(k_ff - 3'd1);

   always_comb begin
      case (f3)
         rvs_pkg::F3_MB: load_ext = {{24{res_ff[7]}}, res_ff[7:0]};
         rvs_pkg::F3_MH: load_ext = {{16{res_ff[15]}}, res_ff[15:0]};
         default:        load_ext = res_ff;
      endcase
   end

   always_comb begin
      case (f3)
         rvs_pkg::F3_BEQ:  taken = eq_ff;
         rvs_pkg::F3_BNE:  taken = ~eq_ff;
         rvs_pkg::F3_BLT:  taken = lt_ff;
         rvs_pkg::F3_BGE:  taken = ~lt_ff;
         rvs_pkg::F3_BLTU: taken = ltu_ff;
         default:          taken = ~ltu_ff;
      endcase
   end

   assign rf_raddr = (state_ff == S_DECODE) ? rs1[3:0] : rs2[3:0];
   assign rf_vaddr = (state_ff == S_RS1) ? rs1[3:0] : rs2[3:0];
   assign rf_value = ((rf_vaddr != 4'd0) && valid_ff[rf_vaddr]) ? rf_rdata : 32'd0;
   assign mem_wdata = (state_ff == S_CLEAR) ? 8'd0 : b_ff[7:0];
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign commit_wr = exec_ff & wres_ff & (rd[3:0] != 4'd0);
   assign csr_write = csr_psel & csr_penable & csr_pwrite &
                      (csr_paddr[3] == rvs_pkg::CSR_IDX_CYCLE_LIMIT);

   // ALU operand selection
   always_comb begin
      alu_ctrl.start = (state_ff == S_START1) || (state_ff == S_START2);
      alu_ctrl.op    = rvs_pkg::ALU_ADD;
      alu_ctrl.x     = a_ff;
      alu_ctrl.y     = imm_i;
      if (state_ff == S_START2) begin
         alu_ctrl.x = pc_ff;
         alu_ctrl.y = (is_branch && taken) ? imm_b : 32'd4;
      end else begin
         case (opc) inside
            rvs_pkg::OPC_OP, rvs_pkg::OPC_OPIMM: begin
               alu_ctrl.y = (opc == rvs_pkg::OPC_OP) ? b_ff : imm_i;
               case (f3) inside
                  rvs_pkg::F3_ADD:
                     alu_ctrl.op = ((opc == rvs_pkg::OPC_OP) && (f7 == rvs_pkg::F7_ALT)) ?
                                   rvs_pkg::ALU_SUB : rvs_pkg::ALU_ADD;
                  rvs_pkg::F3_SLL:                  alu_ctrl.op = rvs_pkg::ALU_SLL;
                  rvs_pkg::F3_SLT, rvs_pkg::F3_SLTU: alu_ctrl.op = rvs_pkg::ALU_SUB;
                  rvs_pkg::F3_XOR:                  alu_ctrl.op = rvs_pkg::ALU_XOR;
                  rvs_pkg::F3_SR:
                     alu_ctrl.op = (f7 == rvs_pkg::F7_ALT) ? rvs_pkg::ALU_SRA :
                                                             rvs_pkg::ALU_SRL;
                  rvs_pkg::F3_OR:                   alu_ctrl.op = rvs_pkg::ALU_OR;
                  default:                          alu_ctrl.op = rvs_pkg::ALU_AND;
               endcase
            end
            rvs_pkg::OPC_STORE:  alu_ctrl.y = imm_s;
            rvs_pkg::OPC_BRANCH: begin
               alu_ctrl.op = rvs_pkg::ALU_SUB;
               alu_ctrl.y  = b_ff;
            end
            rvs_pkg::OPC_JAL: begin
               alu_ctrl.x = pc_ff;
               alu_ctrl.y = imm_j;
            end
            rvs_pkg::OPC_LUI: begin
               alu_ctrl.x = 32'd0;
               alu_ctrl.y = imm_u;
            end
            rvs_pkg::OPC_AUIPC: begin
               alu_ctrl.x = pc_ff;
               alu_ctrl.y = imm_u;
            end
            default: alu_ctrl.y = imm_i;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in    = state_ff;
      pc_in       = pc_ff;
      count_in    = count_ff;
      trap_in     = trap_ff;
      limit_in    = csr_write ? csr_pwdata : limit_ff;
      ins_in      = ins_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      res_in      = res_ff;
      val_in      = val_ff;
      next_pc_in  = next_pc_ff;
      exec_in     = exec_ff;
      wres_in     = wres_ff;
      inrange_in  = inrange_ff;
      eq_in       = eq_ff;
      lt_in       = lt_ff;
      ltu_in      = ltu_ff;
      k_in        = k_ff;
      maddr_in    = maddr_ff;
      valid_in    = valid_ff;
      mem_we      = 1'b0;
      rf_we       = 1'b0;

      rsp_valid_in         = rsp_valid_ff & rsp_stall;
      rsp_executed_in      = rsp_executed_ff;
      rsp_trap_code_in     = rsp_trap_code_ff;
      rsp_pc_now_in        = rsp_pc_now_ff;
      rsp_reg_written_in   = rsp_reg_written_ff;
      rsp_dest_reg_in      = rsp_dest_reg_ff;
      rsp_dest_value_in    = rsp_dest_value_ff;
      rsp_retired_count_in = rsp_retired_count_ff;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we   = 1'b1;
            maddr_in = maddr_ff + AW'(1);
            if (maddr_ff == AW'(MEM_BYTES - 1)) begin
               maddr_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               b_in    = req_word_data;
               exec_in = 1'b0;
               wres_in = 1'b0;
               k_in    = 3'd0;
               if (req_op == rvs_pkg::REQ_OP_LOAD) begin
                  maddr_in   = AW'({req_word_index, 2'b00});
                  inrange_in = (33'({req_word_index, 2'b00}) + 33'd4) <= MEM_LIMIT;
                  state_in   = S_LOAD;
               end else if ((trap_ff != rvs_pkg::TRAP_NONE) || (count_ff >= limit_ff)) begin
                  next_pc_in = pc_ff;
                  state_in   = S_FINISH;
               end else if (({1'b0, pc_ff} + 33'd4) > MEM_LIMIT) begin
                  trap_in    = rvs_pkg::TRAP_MEM;
                  next_pc_in = pc_ff;
                  state_in   = S_FINISH;
               end else begin
                  maddr_in = pc_ff[AW-1:0];
                  state_in = S_FETCH;
               end
            end
         end
         S_LOAD: begin
            mem_we   = inrange_ff;
            b_in     = {8'd0, b_ff[31:8]};
            maddr_in = maddr_ff + AW'(1);
            k_in     = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               next_pc_in = 32'd0;
               state_in   = S_FINISH;
            end
         end
         S_FETCH: begin
            maddr_in = maddr_ff + AW'(1);
            k_in     = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               ins_in = {mem_rdata, ins_ff[31:8]};
            end
            if (k_ff == 3'd4) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!legal) begin
               trap_in    = rvs_pkg::TRAP_ILL;
               next_pc_in = pc_ff;
               state_in   = S_FINISH;
            end else begin
               state_in = S_RS1;
            end
         end
         S_RS1: begin
            a_in     = rf_value;
            state_in = S_RS2;
         end
         S_RS2: begin
            b_in     = rf_value;
            state_in = S_START1;
         end
         S_START1: begin
            state_in = S_WAIT1;
         end
         S_WAIT1: begin
            if (alu_st.done) begin
               res_in = alu_st.result;
               eq_in  = alu_st.eq;
               lt_in  = alu_st.lt;
               ltu_in = alu_st.ltu;
               k_in   = 3'd0;
               if (is_load || is_store) begin
                  if ((33'(alu_st.result) + 33'(acc_size)) > MEM_LIMIT) begin
                     trap_in    = rvs_pkg::TRAP_MEM;
                     next_pc_in = pc_ff;
                     state_in   = S_FINISH;
                  end else begin
                     maddr_in = alu_st.result[AW-1:0];
                     if (is_load) begin
                        res_in = 32'd0;
                     end
                     state_in = S_MEM;
                  end
               end else begin
                  state_in = S_START2;
               end
            end
         end
         S_MEM: begin
            maddr_in = maddr_ff + AW'(1);
            k_in     = k_ff + 3'd1;
            if (is_load) begin
               if (k_ff != 3'd0) begin
                  res_in[lane*8 +: 8] = mem_rdata;
               end
               if (k_ff == acc_size) begin
                  state_in = S_START2;
               end
            end else begin
               mem_we = 1'b1;
               b_in   = {8'd0, b_ff[31:8]};
               if (k_ff == (acc_size - 3'd1)) begin
                  state_in = S_START2;
               end
            end
         end
         S_START2: begin
            state_in = S_WAIT2;
         end
         S_WAIT2: begin
            if (alu_st.done) begin
               exec_in    = 1'b1;
               wres_in    = ~(is_store | is_branch);
               next_pc_in = is_jump ? res_ff : alu_st.result;
               if (is_jump) begin
                  val_in = alu_st.result;
               end else if (is_load) begin
                  val_in = load_ext;
               end else if (((opc == rvs_pkg::OPC_OP) || (opc == rvs_pkg::OPC_OPIMM)) &&
                            (f3 == rvs_pkg::F3_SLT)) begin
                  val_in = {31'd0, lt_ff};
               end else if (((opc == rvs_pkg::OPC_OP) || (opc == rvs_pkg::OPC_OPIMM)) &&
                            (f3 == rvs_pkg::F3_SLTU)) begin
                  val_in = {31'd0, ltu_ff};
               end else begin
                  val_in = res_ff;
               end
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (slot_free) begin
               pc_in    = next_pc_ff;
               count_in = count_ff + {63'd0, exec_ff};
               rf_we    = commit_wr;
               if (commit_wr) begin
                  valid_in[rd[3:0]] = 1'b1;
               end
               rsp_valid_in         = 1'b1;
               rsp_executed_in      = exec_ff;
               rsp_trap_code_in     = trap_ff;
               rsp_pc_now_in        = next_pc_ff;
               rsp_reg_written_in   = commit_wr;
               rsp_dest_reg_in      = commit_wr ? rd[3:0] : 4'd0;
               rsp_dest_value_in    = commit_wr ? val_ff : 32'd0;
               rsp_retired_count_in = count_ff + {63'd0, exec_ff};
               state_in             = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         pc_ff        <= 32'd0;
         count_ff     <= 64'd0;
         trap_ff      <= rvs_pkg::TRAP_NONE;
         limit_ff     <= '1;
         maddr_ff     <= '0;
         valid_ff     <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         count_ff     <= count_in;
         trap_ff      <= trap_in;
         limit_ff     <= limit_in;
         maddr_ff     <= maddr_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ins_ff     <= ins_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      res_ff     <= res_in;
      val_ff     <= val_in;
      next_pc_ff <= next_pc_in;
      exec_ff    <= exec_in;
      wres_ff    <= wres_in;
      inrange_ff <= inrange_in;
      eq_ff      <= eq_in;
      lt_ff      <= lt_in;
      ltu_ff     <= ltu_in;
      k_ff       <= k_in;
      rsp_executed_ff      <= rsp_executed_in;
      rsp_trap_code_ff     <= rsp_trap_code_in;
      rsp_pc_now_ff        <= rsp_pc_now_in;
      rsp_reg_written_ff   <= rsp_reg_written_in;
      rsp_dest_reg_ff      <= rsp_dest_reg_in;
      rsp_dest_value_ff    <= rsp_dest_value_in;
      rsp_retired_count_ff <= rsp_retired_count_in;
   end

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_executed      = rsp_executed_ff;
   assign rsp_trap_code     = rsp_trap_code_ff;
   assign rsp_pc_now        = rsp_pc_now_ff;
   assign rsp_reg_written   = rsp_reg_written_ff;
   assign rsp_dest_reg      = rsp_dest_reg_ff;
   assign rsp_dest_value    = rsp_dest_value_ff;
   assign rsp_retired_count = rsp_retired_count_ff;
   assign csr_pready        = 1'b1;
   assign csr_prdata        = (csr_paddr[3] == rvs_pkg::CSR_IDX_CYCLE_LIMIT) ? limit_ff : 64'd0;

   a_trap_sticky: assert property (@(posedge clock) disable iff (reset)
      (trap_ff != rvs_pkg::TRAP_NONE) |=> (trap_ff == $past(trap_ff)))
      else $error("trap code changed while pending");

   a_count_with_beat: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (rsp_valid_ff && rsp_executed_ff))
      else $error("retired count moved without an executed result");

   a_alu_done_waited: assert property (@(posedge clock) disable iff (reset)
      alu_st.done |-> ((state_ff == S_WAIT1) || (state_ff == S_WAIT2)))
      else $error("ALU finished outside a wait state");

   a_no_mem_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == S_CLEAR) || (state_ff == S_LOAD) ||
                  ((state_ff == S_MEM) && is_store)))
      else $error("byte memory written outside clear, program load or store");

endmodule
